FILE: design/assert_macros.svh
// Concurrent assertion helpers; clocked on clk, disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ARC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ARC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define ARC_ASSERT(lbl, prop, msg)
`define ARC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: design/arc_pkg.sv
package arc_pkg;

	localparam int STORE_BYTES = 2048;
	localparam int AW = $clog2(STORE_BYTES);
	localparam int LW = AW + 1;
	localparam int LANES = 8;
	localparam int ROWS = STORE_BYTES / LANES;
	localparam int RW = $clog2(ROWS);
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_RESPOND = 2'd1,
		CMD_GET     = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	localparam logic [15:0] SW_OK     = 16'h9000;
	localparam logic [15:0] SW_MORE   = 16'h6100;
	localparam logic [15:0] SW_NODATA = 16'h6A86;

	// one emission job for the back end
	typedef struct packed {
		logic          fail;
		logic [LW-1:0] start;
		logic [8:0]    count;
		logic [15:0]   sw;
	} job_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] addr;
		logic [7:0]    data;
	} st_wr_t;

	typedef struct packed {
		logic q_full;
		logic q_empty;
		logic bk_idle;
	} drain_t;

endpackage

FILE: design/arc_if.sv
interface arc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] data_byte;
	logic       last_byte;
	logic [7:0] le_byte;
	logic       le_present;

	modport source(output valid, cmd, data_byte, last_byte, le_byte, le_present, input ready);
	modport sink(input valid, cmd, data_byte, last_byte, le_byte, le_present, output ready);
endinterface

interface arc_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  byte_count;
	logic        is_status;
	logic [15:0] status_word;
	logic        failed;
	logic        last_item;

	modport source(output valid, data_word, byte_count, is_status, status_word, failed,
		last_item, input ready);
	modport sink(input valid, data_word, byte_count, is_status, status_word, failed,
		last_item, output ready);
endinterface

FILE: design/arc_store.sv
module arc_store import arc_pkg::*; (
	input  logic                        clk,
	input  st_wr_t                      st_wr,
	input  logic [LANES-1:0][RW-1:0]    rd_row,
	output logic [LANES-1:0][7:0]       rd_data
);

	// byte address a lives in bank a%8, row a/8
	for (genvar b = 0; b < LANES; b++) begin : g_bank
		logic [7:0] mem [ROWS];

		always_ff @(posedge clk) begin
			if (st_wr.we && (st_wr.addr[2:0] == 3'(b))) begin
				mem[st_wr.addr[AW-1:3]] <= st_wr.data;
			end
			rd_data[b] <= mem[rd_row[b]];
		end
	end

endmodule

FILE: design/arc_queue.sv
module arc_queue import arc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t pop_job,
	output logic full,
	output logic empty
);

	job_t             slots [QDEPTH];
	logic [QAW-1:0]   wptr_q, rptr_q;
	logic [QAW:0]     cnt_q;

	assign full = (cnt_q == (QAW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign pop_job = slots[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: design/arc_front.sv
module arc_front import arc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata,
	arc_in_if.sink     req,
	input  drain_t     drain,
	output logic       push,
	output job_t       job,
	output st_wr_t     st_wr
);

	// (n + 12) % 64 == 0 means n % 64 == 52
	function automatic logic [8:0] avoid_multiple(input logic [8:0] n);
		return (n[5:0] == 6'd52) ? n - 9'd1 : n;
	endfunction

	function automatic logic [15:0] remain_sw(input logic [LW-1:0] r);
		return (r > LW'(255)) ? SW_MORE : (SW_MORE | {8'h00, r[7:0]});
	endfunction

	logic          v_s1;
	cmd_t          cmd_s1;
	logic [7:0]    data_s1;
	logic          last_s1;
	logic [7:0]    le_s1;
	logic          lep_s1;

	logic [8:0]    cap_q;
	logic [LW-1:0] len_q, plen_q, poff_q;
	logic          ovf_q, restart_q;

	logic          go, fire;
	logic [8:0]    cfg_cl;
	logic [8:0]    le_dec, le_cl, le_av, take0, take1, take;
	logic [LW-1:0] base_len, rem_r, remain, new_off, rem_g;
	logic          base_ovf, store_full, fits, has;

	always_comb begin
		case (cmd_s1)
			CMD_LOAD: go = drain.q_empty && drain.bk_idle;
			CMD_RESPOND, CMD_GET: go = !drain.q_full;
			default: go = 1'b1;
		endcase
	end

	assign fire = v_s1 && go;
	assign req.ready = !v_s1 || go;

	always_comb begin
		if (cfg_wdata < 9'd3) begin
			cfg_cl = 9'd3;
		end else if (cfg_wdata > 9'd258) begin
			cfg_cl = 9'd258;
		end else begin
			cfg_cl = cfg_wdata;
		end
	end

	// Le decode, zero byte means 256
	assign le_dec = !lep_s1 ? cap_q : ((le_s1 == 8'd0) ? 9'd256 : {1'b0, le_s1});

	// load
	assign base_len = restart_q ? '0 : len_q;
	assign base_ovf = restart_q ? 1'b0 : ovf_q;
	assign store_full = base_len[AW];
	assign st_wr.we = fire && (cmd_s1 == CMD_LOAD) && !store_full;
	assign st_wr.addr = base_len[AW-1:0];
	assign st_wr.data = data_s1;

	// respond
	assign le_cl = (le_dec > cap_q) ? cap_q : le_dec;
	assign fits = (LW'(le_cl) >= len_q);
	assign le_av = avoid_multiple(le_cl);
	assign rem_r = len_q - LW'(le_av);

	// get response
	assign has = (poff_q < plen_q);
	assign remain = plen_q - poff_q;
	assign take0 = (remain < LW'(le_dec)) ? remain[8:0] : le_dec;
	assign take1 = (take0 > cap_q) ? cap_q : take0;
	assign take = avoid_multiple(take1);
	assign new_off = poff_q + LW'(take);
	assign rem_g = plen_q - new_off;

	always_comb begin
		push = fire && ((cmd_s1 == CMD_RESPOND) || (cmd_s1 == CMD_GET));
		job = '0;
		case (cmd_s1)
			CMD_RESPOND: begin
				if (ovf_q) begin
					job.fail = 1'b1;
				end else if (fits) begin
					job.count = len_q[8:0];
					job.sw = SW_OK;
				end else begin
					job.count = le_av;
					job.sw = remain_sw(rem_r);
				end
			end
			CMD_GET: begin
				if (!has) begin
					job.sw = SW_NODATA;
				end else begin
					job.start = poff_q;
					job.count = take;
					job.sw = (rem_g == '0) ? SW_OK : remain_sw(rem_g);
				end
			end
			default: job = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1 <= cmd_t'(req.cmd);
			data_s1 <= req.data_byte;
			last_s1 <= req.last_byte;
			le_s1 <= req.le_byte;
			lep_s1 <= req.le_present;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			cap_q <= 9'd256;
			len_q <= '0;
			ovf_q <= 1'b0;
			plen_q <= '0;
			poff_q <= '0;
			restart_q <= 1'b1;
		end else begin
			if (req.ready) begin
				v_s1 <= req.valid;
			end
			if (cfg_we) begin
				cap_q <= cfg_cl - 9'd2;
			end
			if (fire) begin
				case (cmd_s1)
					CMD_LOAD: begin
						len_q <= store_full ? base_len : base_len + 1'b1;
						ovf_q <= base_ovf | store_full;
						if (restart_q) begin
							plen_q <= '0;
							poff_q <= '0;
						end
						restart_q <= last_s1;
					end
					CMD_RESPOND: begin
						restart_q <= 1'b1;
						if (ovf_q || fits) begin
							plen_q <= '0;
							poff_q <= '0;
						end else begin
							plen_q <= len_q;
							poff_q <= LW'(le_av);
						end
					end
					CMD_GET: begin
						if (!has || (rem_g == '0)) begin
							plen_q <= '0;
							poff_q <= '0;
						end else begin
							poff_q <= new_off;
						end
					end
					default: restart_q <= restart_q;
				endcase
			end
		end
	end

endmodule

FILE: design/arc_back.sv
module arc_back import arc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  job_t                     q_job,
	output logic                     pop,
	output logic                     idle,
	output logic [LANES-1:0][RW-1:0] rd_row,
	input  logic [LANES-1:0][7:0]    rd_data,
	arc_out_if.source                rsp
);

	typedef enum logic [3:0] {
		BK_IDLE = 4'b0001,
		BK_READ = 4'b0010,
		BK_WORD = 4'b0100,
		BK_STAT = 4'b1000
	} bk_state_t;

	bk_state_t     state_q;
	logic [LW-1:0] cur_q;
	logic [8:0]    left_q;
	logic [15:0]   sw_q;

	logic          ov_q;
	logic [63:0]   word_q;
	logic [3:0]    cnt_q;
	logic          stat_q, fail_q, last_q;

	logic          out_free;
	logic [3:0]    n;
	logic [63:0]   word;

	assign out_free = !ov_q || rsp.ready;
	assign idle = (state_q == BK_IDLE);
	assign pop = idle && q_valid && out_free;
	assign n = (left_q >= 9'd8) ? 4'd8 : left_q[3:0];

	// banks below the start lane read the next row
	for (genvar b = 0; b < LANES; b++) begin : g_row
		assign rd_row[b] = cur_q[AW-1:3] + RW'(3'(b) < cur_q[2:0]);
	end

	always_comb begin
		logic [2:0] lane;
		word = '0;
		for (int i = 0; i < LANES; i++) begin
			lane = cur_q[2:0] + 3'(i);
			if (4'(i) < n) begin
				word[8*i +: 8] = rd_data[lane];
			end
		end
	end

	assign rsp.valid = ov_q;
	assign rsp.data_word = word_q;
	assign rsp.byte_count = cnt_q;
	assign rsp.is_status = stat_q;
	assign rsp.status_word = sw_q & {16{stat_q}};
	assign rsp.failed = fail_q;
	assign rsp.last_item = last_q;

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (pop) begin
					cur_q <= q_job.start;
					left_q <= q_job.count;
					sw_q <= q_job.sw;
					word_q <= '0;
					cnt_q <= '0;
					fail_q <= q_job.fail;
					stat_q <= !q_job.fail;
					last_q <= 1'b1;
				end
			end
			BK_WORD: begin
				if (out_free) begin
					word_q <= word;
					cnt_q <= n;
					stat_q <= 1'b0;
					fail_q <= 1'b0;
					last_q <= 1'b0;
					cur_q <= cur_q + LW'(n);
					left_q <= left_q - 9'(n);
				end
			end
			BK_STAT: begin
				if (out_free) begin
					word_q <= '0;
					cnt_q <= '0;
					stat_q <= 1'b1;
					fail_q <= 1'b0;
					last_q <= 1'b1;
				end
			end
			default: cur_q <= cur_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			ov_q <= 1'b0;
		end else begin
			case (state_q)
				BK_IDLE: begin
					if (pop) begin
						if (q_job.fail || (q_job.count == 9'd0)) begin
							ov_q <= 1'b1;
						end else begin
							ov_q <= 1'b0;
							state_q <= BK_READ;
						end
					end else if (rsp.ready) begin
						ov_q <= 1'b0;
					end
				end
				BK_READ: begin
					if (rsp.ready) begin
						ov_q <= 1'b0;
					end
					state_q <= BK_WORD;
				end
				BK_WORD: begin
					if (out_free) begin
						ov_q <= 1'b1;
						state_q <= (left_q == 9'(n)) ? BK_STAT : BK_READ;
					end
				end
				BK_STAT: begin
					if (out_free) begin
						ov_q <= 1'b1;
						state_q <= BK_IDLE;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

endmodule

FILE: design/apdu_response_chunker.sv
// Smart-card response chunker.
// req: one beat per command. Load beats write the response object one byte per
// cycle; respond and get-response beats produce a run of rsp beats of up to eight
// bytes each, closed by one status beat (9000, 61xx or 6A86) with last_item set,
// or a single failed beat when the loaded object overflowed the store.
// cfg_we/cfg_wdata set the response capacity (status bytes included); write it
// only while the block is idle.
// Flow: a command is registered in the input stage; respond and get-response
// commands are then queued as emission jobs. Each data beat is a bank read of
// the eight-bank byte store, then an output register load; the status beat is
// one more output register load. Loads run at one per cycle, but a load waits
// until all queued emission jobs have drained, since it may overwrite the store.
// Up to four respond/get-response jobs queue between the front end and the
// emitter, so respond and get-response commands keep being accepted while rsp is
// stalled; when the queue fills, req.ready drops.
// Reset: capacity 258, no object, nothing pending; the byte store is not cleared.
`include "assert_macros.svh"

module apdu_response_chunker import arc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata,
	arc_in_if.sink     req,
	arc_out_if.source  rsp
);

	drain_t                   drain;
	logic                     q_push, q_pop, q_full, q_empty, bk_idle;
	job_t                     push_job, q_job;
	st_wr_t                   st_wr;
	logic [LANES-1:0][RW-1:0] rd_row;
	logic [LANES-1:0][7:0]    rd_data;

	assign drain.q_full = q_full;
	assign drain.q_empty = q_empty;
	assign drain.bk_idle = bk_idle;

	arc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.drain    (drain),
		.push     (q_push),
		.job      (push_job),
		.st_wr    (st_wr)
	);

	arc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(push_job),
		.pop     (q_pop),
		.pop_job (q_job),
		.full    (q_full),
		.empty   (q_empty)
	);

	arc_store u_store (
		.clk    (clk),
		.st_wr  (st_wr),
		.rd_row (rd_row),
		.rd_data(rd_data)
	);

	arc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(!q_empty),
		.q_job  (q_job),
		.pop    (q_pop),
		.idle   (bk_idle),
		.rd_row (rd_row),
		.rd_data(rd_data),
		.rsp    (rsp)
	);

	`ARC_ASSERT(a_load_drained, st_wr.we |-> (q_empty && bk_idle), "store written during emission")
	`ARC_ASSERT(a_no_overfill, q_push |-> !q_full, "job pushed into full queue")
	`ARC_ASSERT(a_fail_final, (rsp.valid && rsp.failed) |-> (rsp.last_item && rsp.byte_count == 4'd0), "failed beat not final")
	`ARC_ASSERT_NEXT(a_job_starts, q_pop && !q_job.fail && q_job.count != 9'd0, !bk_idle, "data job not started")

endmodule

FILE: test/apdu_response_chunker_tb.sv
module apdu_response_chunker_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import arc_pkg::*;

	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES = 20;
	localparam int unsigned RANDOM_PER_SETTING = 36;
	localparam int unsigned SCRIPT_ROWS = 24;
	localparam int unsigned NUM_SETTINGS = 6;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] data_byte;
		logic       last_byte;
		logic [7:0] le_byte;
		logic       le_present;
	} cmd_item_t;

	typedef struct packed {
		logic [63:0] data_word;
		logic [3:0]  byte_count;
		logic        is_status;
		logic [15:0] status_word;
		logic        failed;
		logic        last_item;
	} rsp_beat_t;

	typedef struct packed {
		cmd_item_t   item;
		logic        typed;
		logic [15:0] typed_sw;
	} script_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [8:0] cfg_wdata;

	arc_in_if  req_if();
	arc_out_if rsp_if();

	apdu_response_chunker u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	always #6 clk = ~clk;

	// chunker state as the block should hold it
	logic [7:0]  obj_mem [STORE_BYTES];
	int unsigned obj_len;
	bit          obj_overflow;
	bit          obj_restart;
	int unsigned pend_len;
	int unsigned pend_off;
	logic [8:0]  capacity_reg;

	rsp_beat_t   chunk_beats [$];
	rsp_beat_t   response_due [$];

	int unsigned cmds_sent;
	int unsigned beats_checked;
	int unsigned settings_tried;
	int unsigned mismatches;
	int unsigned send_calm;
	int unsigned recv_calm;
	bit          long_hold_req;
	bit          long_hold_seen;

	function automatic int unsigned data_limit();
		int unsigned c;
		c = capacity_reg;
		if (c < 3) c = 3;
		if (c > 258) c = 258;
		return c - 2;
	endfunction

	// keep a chunk plus header/status overhead off a 64-byte packet boundary
	function automatic int unsigned trim_chunk(input int unsigned n);
		if (((n + 12) % 64) == 0 && n > 1) return n - 1;
		return n;
	endfunction

	function automatic logic [15:0] remain_sw(input int unsigned remain);
		return SW_MORE | 16'(remain > 255 ? 0 : remain);
	endfunction

	function automatic rsp_beat_t status_beat(input logic [15:0] sw);
		rsp_beat_t b;
		b = '0;
		b.is_status = 1'b1;
		b.status_word = sw;
		b.last_item = 1'b1;
		return b;
	endfunction

	function automatic rsp_beat_t fail_beat();
		rsp_beat_t b;
		b = '0;
		b.failed = 1'b1;
		b.last_item = 1'b1;
		return b;
	endfunction

	task automatic stage_bytes(input int unsigned start, input int unsigned count);
		int unsigned done, n;
		rsp_beat_t b;
		done = 0;
		while (done < count) begin
			n = count - done;
			if (n > 8) n = 8;
			b = '0;
			for (int unsigned i = 0; i < n; i++)
				b.data_word |= 64'(obj_mem[start + done + i]) << (8 * i);
			b.byte_count = 4'(n);
			chunk_beats.push_back(b);
			done += n;
		end
	endtask

	task automatic chunk_response(input cmd_item_t it);
		int unsigned lim, le, remain, take;
		chunk_beats.delete();
		lim = data_limit();
		if (!it.le_present) le = lim;
		else le = (it.le_byte == 8'd0) ? 256 : it.le_byte;
		case (it.cmd)
			CMD_LOAD: begin
				if (obj_restart) begin
					obj_len = 0;
					obj_overflow = 1'b0;
					pend_len = 0;
					pend_off = 0;
					obj_restart = 1'b0;
				end
				if (obj_len < STORE_BYTES) begin
					obj_mem[obj_len] = it.data_byte;
					obj_len++;
				end else begin
					obj_overflow = 1'b1;
				end
				if (it.last_byte) obj_restart = 1'b1;
			end
			CMD_RESPOND: begin
				obj_restart = 1'b1;
				pend_len = 0;
				pend_off = 0;
				if (obj_overflow) begin
					chunk_beats.push_back(fail_beat());
				end else begin
					if (le > lim) le = lim;
					if (le >= obj_len) begin
						stage_bytes(0, obj_len);
						chunk_beats.push_back(status_beat(SW_OK));
					end else begin
						le = trim_chunk(le);
						pend_len = obj_len;
						pend_off = le;
						stage_bytes(0, le);
						chunk_beats.push_back(status_beat(remain_sw(obj_len - le)));
					end
				end
			end
			CMD_GET: begin
				if (pend_off >= pend_len) begin
					pend_len = 0;
					pend_off = 0;
					chunk_beats.push_back(status_beat(SW_NODATA));
				end else begin
					remain = pend_len - pend_off;
					take = (remain < le) ? remain : le;
					if (take > lim) take = lim;
					take = trim_chunk(take);
					stage_bytes(pend_off, take);
					pend_off += take;
					remain = pend_len - pend_off;
					if (remain == 0) begin
						pend_len = 0;
						pend_off = 0;
						chunk_beats.push_back(status_beat(SW_OK));
					end else begin
						chunk_beats.push_back(status_beat(remain_sw(remain)));
					end
				end
			end
			default: ;
		endcase
	endtask

	function automatic script_row_t row(input cmd_t c, input logic [7:0] d, input logic last,
			input logic [7:0] le, input logic lep, input logic typed, input logic [15:0] sw);
		script_row_t r;
		r.item = '{c, d, last, le, lep};
		r.typed = typed;
		r.typed_sw = sw;
		return r;
	endfunction

	function automatic cmd_item_t load_item(input logic [7:0] d, input logic last);
		cmd_item_t it;
		it = '{CMD_LOAD, d, last, 8'($urandom), 1'($urandom)};
		return it;
	endfunction

	function automatic cmd_item_t rand_le(input cmd_t c);
		cmd_item_t it;
		it.cmd = c;
		it.data_byte = 8'($urandom);
		it.last_byte = 1'($urandom);
		it.le_present = ($urandom_range(0, 3) != 0);
		case ($urandom_range(0, 7))
			0: it.le_byte = 8'd0;
			1: it.le_byte = 8'd1;
			2: it.le_byte = 8'd255;
			3: it.le_byte = 8'(52 + 64 * $urandom_range(0, 3));
			4: it.le_byte = 8'(51 + 2 * $urandom_range(0, 1) + 64 * $urandom_range(0, 3));
			5: it.le_byte = 8'($urandom_range(1, 16));
			default: it.le_byte = 8'($urandom);
		endcase
		return it;
	endfunction

	// gap before the next beat; now and then a run of back-to-back beats
	task automatic draw_gap(inout int unsigned calm, output int unsigned gap);
		if (calm != 0) begin
			calm--;
			gap = 0;
		end else if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(8, 32);
			gap = 0;
		end else begin
			gap = $urandom_range(0, 8);
		end
	endtask

	task automatic send_cmd(input cmd_item_t it, input bit typed, input rsp_beat_t typed_beat);
		int unsigned gap;
		draw_gap(send_calm, gap);
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.cmd <= it.cmd;
		req_if.data_byte <= it.data_byte;
		req_if.last_byte <= it.last_byte;
		req_if.le_byte <= it.le_byte;
		req_if.le_present <= it.le_present;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		chunk_response(it);
		if (typed) response_due.push_back(typed_beat);
		else foreach (chunk_beats[i]) response_due.push_back(chunk_beats[i]);
		if (it.cmd != CMD_NONE) cmds_sent++;
	endtask

	task automatic load_object(input int unsigned len, input bit close);
		for (int unsigned i = 0; i < len; i++)
			send_cmd(load_item(8'($urandom), close && i == len - 1), 1'b0, '0);
	endtask

	task automatic settle();
		req_if.valid <= 1'b0;
		while (response_due.size() != 0) @(posedge clk);
		// a trailing load leaves no beat behind to wait on
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [8:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		capacity_reg = v;
		settings_tried++;
	endtask

	task automatic run_random(input int unsigned budget);
		int unsigned stop_at, len, guard;
		cmd_item_t it;
		stop_at = cmds_sent + budget;
		while (cmds_sent < stop_at) begin
			if ($urandom_range(0, 9) < 7) begin
				if (data_limit() >= 50 && $urandom_range(0, 39) == 0) len = $urandom_range(200, 300);
				else len = $urandom_range(1, 24);
				load_object(len, 1'b1);
				send_cmd(rand_le(CMD_RESPOND), 1'b0, '0);
				guard = 0;
				// occasionally abandon the chain; the next object replaces it
				while (pend_len != 0 && guard < 300 && $urandom_range(0, 11) != 0) begin
					send_cmd(rand_le(CMD_GET), 1'b0, '0);
					guard++;
				end
				if ($urandom_range(0, 5) == 0) send_cmd(rand_le(CMD_GET), 1'b0, '0);
			end else begin
				case ($urandom_range(0, 2))
					0: begin
						it = '{cmd_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
							8'($urandom), 1'($urandom)};
						send_cmd(it, 1'b0, '0);
					end
					1: begin
						load_object($urandom_range(1, 6), 1'b0);
						send_cmd(rand_le(CMD_RESPOND), 1'b0, '0);
					end
					default: send_cmd(rand_le(cmd_t'($urandom_range(1, 2))), 1'b0, '0);
				endcase
			end
		end
	endtask

	task automatic flag_beat(input bit stray, input rsp_beat_t want, input rsp_beat_t got);
		mismatches++;
		if (mismatches <= 10) begin
			if (stray)
				$display("unexpected beat: data=%h cnt=%0d st=%b sw=%h fail=%b last=%b",
					got.data_word, got.byte_count, got.is_status, got.status_word,
					got.failed, got.last_item);
			else
				$display("beat mismatch: want data=%h cnt=%0d st=%b sw=%h fail=%b last=%b",
					want.data_word, want.byte_count, want.is_status, want.status_word,
					want.failed, want.last_item, "\n               got data=%h cnt=%0d st=%b sw=%h fail=%b last=%b",
					got.data_word, got.byte_count, got.is_status, got.status_word,
					got.failed, got.last_item);
		end
	endtask

	initial begin : rsp_side
		int unsigned gap;
		rsp_beat_t got, want;
		wait (arst_n === 1'b1);
		forever begin
			draw_gap(recv_calm, gap);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				long_hold_seen = 1'b1;
				gap = LONG_HOLD;
			end
			if (gap != 0) begin
				rsp_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (rsp_if.valid !== 1'b1);
			got.data_word = rsp_if.data_word;
			got.byte_count = rsp_if.byte_count;
			got.is_status = rsp_if.is_status;
			got.status_word = rsp_if.status_word;
			got.failed = rsp_if.failed;
			got.last_item = rsp_if.last_item;
			beats_checked++;
			if (response_due.size() == 0) begin
				flag_beat(1'b1, '0, got);
			end else begin
				want = response_due.pop_front();
				if (got !== want) flag_beat(1'b0, want, got);
			end
		end
	end

	initial begin : watchdog
		int unsigned idle;
		idle = 0;
		wait (arst_n === 1'b1);
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
					(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
				idle = 0;
			else
				idle++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		script_row_t script [SCRIPT_ROWS];
		logic [8:0]  random_caps [NUM_SETTINGS];

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_if.valid = 1'b0;
		req_if.cmd = CMD_LOAD;
		req_if.data_byte = '0;
		req_if.last_byte = 1'b0;
		req_if.le_byte = '0;
		req_if.le_present = 1'b0;
		rsp_if.ready = 1'b0;

		obj_len = 0;
		obj_overflow = 1'b0;
		obj_restart = 1'b1;
		pend_len = 0;
		pend_off = 0;
		capacity_reg = 9'd258;
		cmds_sent = 0;
		beats_checked = 0;
		settings_tried = 1;
		mismatches = 0;
		send_calm = 0;
		recv_calm = 0;
		long_hold_req = 1'b0;
		long_hold_seen = 1'b0;

		script = '{
			row(CMD_GET,     8'h00, 1'b0, 8'h00, 1'b0, 1'b1, SW_NODATA),  // nothing pending yet
			row(CMD_RESPOND, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, SW_OK),      // empty object
			row(CMD_NONE,    8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0, '0),
			row(CMD_LOAD,    8'h00, 1'b0, 8'h00, 1'b0, 1'b0, '0),
			row(CMD_LOAD,    8'hFF, 1'b0, 8'hFF, 1'b1, 1'b0, '0),
			row(CMD_LOAD,    8'hA5, 1'b0, 8'h00, 1'b0, 1'b0, '0),
			row(CMD_LOAD,    8'h5A, 1'b0, 8'h00, 1'b0, 1'b0, '0),
			row(CMD_LOAD,    8'h01, 1'b0, 8'h00, 1'b0, 1'b0, '0),
			row(CMD_LOAD,    8'h80, 1'b0, 8'h00, 1'b0, 1'b0, '0),
			row(CMD_LOAD,    8'h7F, 1'b0, 8'h00, 1'b0, 1'b0, '0),
			row(CMD_LOAD,    8'hFE, 1'b1, 8'hFF, 1'b1, 1'b0, '0),
			row(CMD_RESPOND, 8'h00, 1'b0, 8'h03, 1'b1, 1'b0, '0),
			row(CMD_GET,     8'h00, 1'b0, 8'h00, 1'b1, 1'b0, '0),         // Le 0 reads as 256
			row(CMD_GET,     8'h00, 1'b0, 8'h00, 1'b0, 1'b1, SW_NODATA),
			row(CMD_RESPOND, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, '0),         // resend stored object
			row(CMD_LOAD,    8'h11, 1'b0, 8'h00, 1'b0, 1'b0, '0),
			row(CMD_LOAD,    8'h22, 1'b0, 8'h00, 1'b0, 1'b0, '0),
			row(CMD_LOAD,    8'h33, 1'b0, 8'h00, 1'b0, 1'b0, '0),
			row(CMD_RESPOND, 8'h00, 1'b0, 8'hFF, 1'b1, 1'b0, '0),         // object not closed
			row(CMD_LOAD,    8'hC3, 1'b1, 8'h00, 1'b0, 1'b0, '0),
			row(CMD_GET,     8'h00, 1'b0, 8'h01, 1'b1, 1'b1, SW_NODATA),
			row(CMD_RESPOND, 8'h00, 1'b0, 8'h01, 1'b1, 1'b0, '0),
			row(CMD_RESPOND, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, '0),
			row(CMD_GET,     8'h00, 1'b0, 8'h00, 1'b0, 1'b1, SW_NODATA)
		};
		random_caps = '{9'd3, 9'd54, 9'd511, 9'd0, 9'd118, 9'd200};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_cmd(script[i].item, script[i].typed, status_beat(script[i].typed_sw));

		// output held off while small jobs pile up behind it
		settle();
		load_object(40, 1'b1);
		long_hold_req = 1'b1;
		send_cmd('{CMD_RESPOND, 8'h00, 1'b0, 8'd4, 1'b1}, 1'b0, '0);
		repeat (9) send_cmd('{CMD_GET, 8'h00, 1'b0, 8'd4, 1'b1}, 1'b0, '0);

		foreach (random_caps[i]) begin
			set_capacity(random_caps[i]);
			run_random(RANDOM_PER_SETTING);
		end

		req_if.valid <= 1'b0;
		while (response_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Covered %0d commands and %0d response beats over %0d capacity settings,",
			cmds_sent, beats_checked, settings_tried);
		$display("including a %0d-cycle output stall (engaged=%0b); %0d mismatches",
			LONG_HOLD, long_hold_seen, mismatches);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
